@@ sv/aqi_pkg.sv @@
// Package for the air quality index scorer: transaction types, fixed-point
// scale, piecewise-linear curve tables and the curve evaluation function.
// Used by air_quality_index_scorer_core; depends on nothing.
`default_nettype none

package aqi_pkg;

  // Subscores are kept scaled by 6600, which makes every curve segment an
  // integer slope and every subscore an exact integer (100 -> 660000).
  localparam int unsigned SCORE_W = 20;
  localparam logic [SCORE_W-1:0] SCORE_TOP = 20'd660000;

  localparam int unsigned TEN_N_W = 21;
  localparam int unsigned TEN_DIV = 1320;
  localparam int unsigned TEN_RND = 660;
  localparam int unsigned TEN_M = (2 ** TEN_N_W) / TEN_DIV;
  localparam int unsigned TEN_M_W = 11;
  localparam int unsigned TEN_Q_W = 11;

  localparam int unsigned LED_DIV = 1320000;
  localparam int unsigned LED_RND = 660000;

  typedef struct packed {
    logic [13:0] pm25_tenths;
    logic        pm25_valid;
    logic [13:0] pm10_tenths;
    logic        pm10_valid;
    logic [15:0] co2_ppm;
    logic        co2_valid;
    logic [8:0]  voc_level;
    logic        voc_valid;
    logic [8:0]  nox_level;
    logic        nox_valid;
  } aqi_in_t;

  typedef struct packed {
    logic       index_valid;
    logic [9:0] index_tenths;
    logic [3:0] lit_leds;
  } aqi_out_t;

  typedef struct packed {
    logic [15:0]        lo;
    logic [15:0]        hi;
    logic [SCORE_W-1:0] base;
    logic [11:0]        slope;
  } aqi_seg_t;

  typedef struct packed {
    logic [SCORE_W-1:0] floor_score;
    aqi_seg_t [0:3]     seg;
  } aqi_curve_t;

  localparam aqi_curve_t PM25_CURVE = '{
    floor_score: 20'd0,
    seg: '{
      '{lo: 16'd0,   hi: 16'd100, base: 20'd0,      slope: 12'd1320},
      '{lo: 16'd100, hi: 16'd250, base: 20'd132000, slope: 12'd1320},
      '{lo: 16'd250, hi: 16'd500, base: 20'd330000, slope: 12'd660},
      '{lo: 16'd500, hi: 16'd750, base: 20'd495000, slope: 12'd396}
    }
  };

  localparam aqi_curve_t PM10_CURVE = '{
    floor_score: 20'd0,
    seg: '{
      '{lo: 16'd0,   hi: 16'd200,  base: 20'd0,      slope: 12'd660},
      '{lo: 16'd200, hi: 16'd450,  base: 20'd132000, slope: 12'd1056},
      '{lo: 16'd450, hi: 16'd1000, base: 20'd396000, slope: 12'd360},
      '{lo: 16'd0,   hi: 16'd0,    base: 20'd0,      slope: 12'd0}
    }
  };

  localparam aqi_curve_t CO2_CURVE = '{
    floor_score: 20'd0,
    seg: '{
      '{lo: 16'd400,  hi: 16'd800,  base: 20'd0,      slope: 12'd330},
      '{lo: 16'd800,  hi: 16'd1000, base: 20'd132000, slope: 12'd660},
      '{lo: 16'd1000, hi: 16'd1400, base: 20'd264000, slope: 12'd495},
      '{lo: 16'd1400, hi: 16'd2000, base: 20'd462000, slope: 12'd220}
    }
  };

  localparam aqi_curve_t VOC_CURVE = '{
    floor_score: 20'd66000,
    seg: '{
      '{lo: 16'd100, hi: 16'd200, base: 20'd66000,  slope: 12'd3300},
      '{lo: 16'd200, hi: 16'd300, base: 20'd396000, slope: 12'd1650},
      '{lo: 16'd300, hi: 16'd500, base: 20'd561000, slope: 12'd495},
      '{lo: 16'd0,   hi: 16'd0,   base: 20'd0,      slope: 12'd0}
    }
  };

  function automatic logic [SCORE_W-1:0] curve_score(input logic [15:0] x,
                                                     input aqi_curve_t c);
    logic [SCORE_W-1:0] b;
    logic [11:0]        k;
    logic [9:0]         diff;
    logic [21:0]        p;
    b    = SCORE_TOP;
    k    = '0;
    diff = '0;
    for (int i = 0; i < 4; i++) begin
      if (x > c.seg[i].lo && x <= c.seg[i].hi) begin
        b    = c.seg[i].base;
        k    = c.seg[i].slope;
        diff = 10'(x - c.seg[i].lo);
      end
    end
    p = 22'(k) * 22'(diff);
    if (x <= c.seg[0].lo) begin
      return c.floor_score;
    end
    return b + p[SCORE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/air_quality_index_scorer_core.sv @@
// Air quality index scorer: curve lookup, worst-subscore select, rounding.
// Depends on aqi_pkg for transaction types, curve tables and scale constants.
//
// One transaction is taken per clock and its result passes through five register
// stages: input register, subscore maximum, rounding numerators,
// reciprocal multiply, remainder correction into the result register. The
// rate is one transaction per cycle, bounded only by result_ready; each stage
// holds its contents while the stage after it is full and stalled, so the
// pipe keeps taking transactions until all five stages are occupied.
`default_nettype none

module air_quality_index_scorer_core #(
  parameter int unsigned RING_LEDS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  sample_ready,
  input  wire aqi_pkg::aqi_in_t sample,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output aqi_pkg::aqi_out_t     result
);

  localparam int unsigned NL_MAX = aqi_pkg::LED_DIV * RING_LEDS + aqi_pkg::LED_RND;
  localparam int unsigned NL_W   = $clog2(NL_MAX + 1);
  localparam int unsigned LED_M  = (2 ** NL_W) / aqi_pkg::LED_DIV;
  localparam int unsigned LED_M_W = $clog2(LED_M + 1);
  localparam int unsigned LQ_W   = $clog2(RING_LEDS + 2);

  logic v1, v2, v3, v4, v5;
  logic rdy2, rdy3, rdy4, rdy5;

  aqi_pkg::aqi_in_t             in_r;
  logic [aqi_pkg::SCORE_W-1:0]  score_r;
  logic                         have2;
  logic [aqi_pkg::TEN_N_W-1:0]  nt3, nt4;
  logic [NL_W-1:0]              nl3, nl4;
  logic                         have3, have4;
  logic [aqi_pkg::TEN_Q_W-1:0]  qt4;
  logic [LQ_W-1:0]              ql4;
  aqi_pkg::aqi_out_t            out_r;

  logic [aqi_pkg::SCORE_W-1:0]  sc [5];
  logic [4:0]                   sv;
  logic [aqi_pkg::SCORE_W-1:0]  score_next;
  logic                         have_next;
  logic [aqi_pkg::TEN_N_W-1:0]  nt_next;
  logic [NL_W-1:0]              nl_next;
  logic [aqi_pkg::TEN_N_W+aqi_pkg::TEN_M_W-1:0] prod_t;
  logic [NL_W+LED_M_W-1:0]      prod_l;
  logic [aqi_pkg::TEN_Q_W-1:0]  qt_next;
  logic [LQ_W-1:0]              ql_next;
  logic [aqi_pkg::TEN_N_W:0]    rem_t;
  logic [NL_W-1:0]              rem_l;
  aqi_pkg::aqi_out_t            out_next;

  assign rdy5         = !v5 || result_ready;
  assign rdy4         = !v4 || rdy5;
  assign rdy3         = !v3 || rdy4;
  assign rdy2         = !v2 || rdy3;
  assign sample_ready = !v1 || rdy2;
  assign result_valid = v5;
  assign result       = out_r;

  always_comb begin
    sc[0] = aqi_pkg::curve_score({2'b00, in_r.pm25_tenths}, aqi_pkg::PM25_CURVE);
    sc[1] = aqi_pkg::curve_score({2'b00, in_r.pm10_tenths}, aqi_pkg::PM10_CURVE);
    sc[2] = aqi_pkg::curve_score(in_r.co2_ppm, aqi_pkg::CO2_CURVE);
    sc[3] = aqi_pkg::curve_score({7'd0, in_r.voc_level}, aqi_pkg::VOC_CURVE);
    sc[4] = aqi_pkg::curve_score({7'd0, in_r.nox_level}, aqi_pkg::VOC_CURVE);
    sv    = {in_r.nox_valid, in_r.voc_valid, in_r.co2_valid,
             in_r.pm10_valid, in_r.pm25_valid};
    have_next  = |sv;
    score_next = '0;
    for (int i = 0; i < 5; i++) begin
      if (sv[i] && sc[i] > score_next) begin
        score_next = sc[i];
      end
    end
  end

  always_comb begin
    nt_next = aqi_pkg::TEN_N_W'({score_r, 1'b0}) + aqi_pkg::TEN_N_W'(aqi_pkg::TEN_RND);
    nl_next = NL_W'(NL_W'(score_r) * NL_W'(2 * RING_LEDS)) + NL_W'(aqi_pkg::LED_RND);
  end

  always_comb begin
    prod_t  = (aqi_pkg::TEN_N_W + aqi_pkg::TEN_M_W)'(nt3)
            * (aqi_pkg::TEN_N_W + aqi_pkg::TEN_M_W)'(aqi_pkg::TEN_M);
    prod_l  = (NL_W + LED_M_W)'(nl3) * (NL_W + LED_M_W)'(LED_M);
    qt_next = aqi_pkg::TEN_Q_W'(prod_t >> aqi_pkg::TEN_N_W);
    ql_next = LQ_W'(prod_l >> NL_W);
  end

  always_comb begin
    rem_t = (aqi_pkg::TEN_N_W + 1)'(nt4)
          - (aqi_pkg::TEN_N_W + 1)'(qt4 * aqi_pkg::TEN_DIV);
    rem_l = nl4 - NL_W'(ql4 * aqi_pkg::LED_DIV);
    out_next.index_valid  = have4;
    out_next.index_tenths = 10'(qt4 + aqi_pkg::TEN_Q_W'(
                              rem_t >= (aqi_pkg::TEN_N_W + 1)'(aqi_pkg::TEN_DIV)));
    out_next.lit_leds     = 4'(ql4 + LQ_W'(rem_l >= NL_W'(aqi_pkg::LED_DIV)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (sample_ready) begin
        v1 <= sample_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_r <= sample;
    end
    if (v1 && rdy2) begin
      score_r <= score_next;
      have2   <= have_next;
    end
    if (v2 && rdy3) begin
      nt3   <= nt_next;
      nl3   <= nl_next;
      have3 <= have2;
    end
    if (v3 && rdy4) begin
      nt4   <= nt3;
      nl4   <= nl3;
      qt4   <= qt_next;
      ql4   <= ql_next;
      have4 <= have3;
    end
    if (v4 && rdy5) begin
      out_r <= out_next;
    end
  end

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> score_r <= aqi_pkg::SCORE_TOP)
    else $error("worst subscore above full scale");

  a_tenths_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.index_tenths <= 10'd1000)
    else $error("index above 100.0");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.index_valid |->
      result.index_tenths == 10'd0 && result.lit_leds == 4'd0)
    else $error("invalid index with nonzero fields");

  a_leds_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (RING_LEDS > 15) || (result.lit_leds <= 4'(RING_LEDS)))
    else $error("more LEDs lit than the ring holds");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !rdy5 |=> v4)
    else $error("stalled stage lost its transaction");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for air_quality_index_scorer_core: queue-fed driver, monitor and
// an exact integer scoring predictor of the four sensor curves.
// Depends on aqi_pkg for the sample and result transaction types.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING = 12;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 1200;
  // common multiple of every curve segment width, so each subscore is an integer
  localparam longint unsigned SCALE = 66000;

  typedef enum int unsigned { CURVE_PM25, CURVE_PM10, CURVE_CO2, CURVE_VOC } curve_e;

  localparam logic [4:0][15:0] PM25_X = {16'd750, 16'd500, 16'd250, 16'd100, 16'd0};
  localparam logic [4:0][15:0] PM25_Y = {16'd90, 16'd75, 16'd50, 16'd20, 16'd0};
  localparam logic [4:0][15:0] PM10_X = {16'd0, 16'd1000, 16'd450, 16'd200, 16'd0};
  localparam logic [4:0][15:0] PM10_Y = {16'd0, 16'd90, 16'd60, 16'd20, 16'd0};
  localparam logic [4:0][15:0] CO2_X = {16'd2000, 16'd1400, 16'd1000, 16'd800, 16'd400};
  localparam logic [4:0][15:0] CO2_Y = {16'd90, 16'd70, 16'd40, 16'd20, 16'd0};
  localparam logic [4:0][15:0] VOC_X = {16'd0, 16'd500, 16'd300, 16'd200, 16'd100};
  localparam logic [4:0][15:0] VOC_Y = {16'd0, 16'd100, 16'd85, 16'd60, 16'd10};

  typedef struct {
    aqi_pkg::aqi_in_t data;
    bit               drain_first;
  } feed_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  aqi_pkg::aqi_in_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  aqi_pkg::aqi_out_t result;

  feed_item_t feed_q[$];
  aqi_pkg::aqi_out_t expected_q[$];
  int unsigned total_items = 0;
  int unsigned accepted_items = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm = 0;

  air_quality_index_scorer_core #(.RING_LEDS(RING)) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic int unsigned bp_count(curve_e c);
    case (c)
      CURVE_PM25: return 5;
      CURVE_CO2:  return 5;
      default:    return 4;
    endcase
  endfunction

  function automatic int unsigned bp_x(curve_e c, int unsigned i);
    case (c)
      CURVE_PM25: return PM25_X[i];
      CURVE_PM10: return PM10_X[i];
      CURVE_CO2:  return CO2_X[i];
      default:    return VOC_X[i];
    endcase
  endfunction

  function automatic int unsigned bp_y(curve_e c, int unsigned i);
    case (c)
      CURVE_PM25: return PM25_Y[i];
      CURVE_PM10: return PM10_Y[i];
      CURVE_CO2:  return CO2_Y[i];
      default:    return VOC_Y[i];
    endcase
  endfunction

  function automatic longint unsigned sensor_subscore(curve_e c, int unsigned x);
    longint unsigned x0, x1, y0, y1;
    if (x <= bp_x(c, 0)) return bp_y(c, 0) * SCALE;
    for (int unsigned i = 1; i < bp_count(c); i++) begin
      if (x <= bp_x(c, i)) begin
        x0 = bp_x(c, i - 1);
        x1 = bp_x(c, i);
        y0 = bp_y(c, i - 1);
        y1 = bp_y(c, i);
        return (y0 * (x1 - x0) + (y1 - y0) * (x - x0)) * (SCALE / (x1 - x0));
      end
    end
    return 100 * SCALE;
  endfunction

  function automatic aqi_pkg::aqi_out_t predict_index(aqi_pkg::aqi_in_t s);
    aqi_pkg::aqi_out_t r;
    longint unsigned worst, sc;
    bit have;
    have = 1'b0;
    worst = 0;
    if (s.pm25_valid) begin
      sc = sensor_subscore(CURVE_PM25, s.pm25_tenths);
      if (!have || sc > worst) worst = sc;
      have = 1'b1;
    end
    if (s.pm10_valid) begin
      sc = sensor_subscore(CURVE_PM10, s.pm10_tenths);
      if (!have || sc > worst) worst = sc;
      have = 1'b1;
    end
    if (s.co2_valid) begin
      sc = sensor_subscore(CURVE_CO2, s.co2_ppm);
      if (!have || sc > worst) worst = sc;
      have = 1'b1;
    end
    if (s.voc_valid) begin
      sc = sensor_subscore(CURVE_VOC, s.voc_level);
      if (!have || sc > worst) worst = sc;
      have = 1'b1;
    end
    if (s.nox_valid) begin
      sc = sensor_subscore(CURVE_VOC, s.nox_level);
      if (!have || sc > worst) worst = sc;
      have = 1'b1;
    end
    r = '0;
    if (have) begin
      r.index_valid = 1'b1;
      r.index_tenths = 10'((2 * worst * 10 + SCALE) / (2 * SCALE));
      r.lit_leds = 4'((2 * worst * RING + SCALE * 100) / (2 * SCALE * 100));
    end
    return r;
  endfunction

  function automatic int unsigned draw_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int unsigned pick_reading(curve_e c, int unsigned range_max,
                                               int unsigned width_max);
    int unsigned r, b, d;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, range_max);
    if (r < 75) begin
      b = bp_x(c, $urandom_range(0, bp_count(c) - 1));
      d = $urandom_range(0, 6);
      return (b + d < 3) ? 0 : b + d - 3;
    end
    if (r < 88) return $urandom_range(0, width_max);
    return $urandom_range(0, bp_x(c, bp_count(c) - 1) + 20);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic add_item(int unsigned pm25, bit pm25_v, int unsigned pm10, bit pm10_v,
                          int unsigned co2, bit co2_v, int unsigned voc, bit voc_v,
                          int unsigned nox, bit nox_v, bit drain);
    feed_item_t it;
    it.data.pm25_tenths = 14'(pm25);
    it.data.pm25_valid = pm25_v;
    it.data.pm10_tenths = 14'(pm10);
    it.data.pm10_valid = pm10_v;
    it.data.co2_ppm = 16'(co2);
    it.data.co2_valid = co2_v;
    it.data.voc_level = 9'(voc);
    it.data.voc_valid = voc_v;
    it.data.nox_level = 9'(nox);
    it.data.nox_valid = nox_v;
    it.drain_first = drain;
    feed_q.push_back(it);
    total_items++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (sample_valid && sample_ready) begin
        expected_q.push_back(predict_index(sample));
        accepted_items++;
      end
      if (!sample_valid || sample_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          sample_valid <= 1'b0;
        end else if (feed_q.size() > 0 &&
                     !(feed_q[0].drain_first && expected_q.size() > 0)) begin
          sample <= feed_q[0].data;
          sample_valid <= 1'b1;
          feed_q.pop_front();
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = draw_pause();
            if ($urandom_range(0, 99) < 2) tx_calm = $urandom_range(40, 120);
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      result_ready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      result_ready <= 1'b1;
    end else begin
      rx_stall = draw_pause();
      if ($urandom_range(0, 99) < 2) rx_calm = $urandom_range(40, 120);
      if (rx_stall > 0) begin
        rx_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    aqi_pkg::aqi_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with none expected", 32'(result), 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (result.index_valid !== want.index_valid)
          report_mismatch("index_valid", 32'(result.index_valid), 32'(want.index_valid));
        if (result.index_tenths !== want.index_tenths)
          report_mismatch("index_tenths", 32'(result.index_tenths), 32'(want.index_tenths));
        if (result.lit_leds !== want.lit_leds)
          report_mismatch("lit_leds", 32'(result.lit_leds), 32'(want.lit_leds));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    bit timed_out;
    bit any_on;
    bit pv, mv, cv, vv, nv;
    timed_out = 1'b0;

    add_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(16383, 0, 16383, 0, 65535, 0, 511, 0, 511, 0, 0);
    add_item(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(750, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(751, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(16383, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 451, 1, 0, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 1000, 1, 0, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 1001, 1, 0, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 16383, 1, 0, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 399, 1, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 400, 1, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 1001, 1, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 2000, 1, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 65535, 1, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 100, 1, 0, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 500, 1, 0, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 511, 1, 0, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 0, 0, 100, 1, 0);
    add_item(0, 0, 0, 0, 0, 0, 0, 0, 501, 1, 0);
    add_item(0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0);
    add_item(16383, 1, 16383, 1, 65535, 1, 511, 1, 511, 1, 0);
    add_item(125, 1, 333, 1, 1234, 1, 250, 1, 150, 1, 0);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      any_on = ($urandom_range(0, 99) >= 4);
      pv = any_on && ($urandom_range(0, 9) < 7);
      mv = any_on && ($urandom_range(0, 9) < 7);
      cv = any_on && ($urandom_range(0, 9) < 7);
      vv = any_on && ($urandom_range(0, 9) < 7);
      nv = any_on && ($urandom_range(0, 9) < 7);
      add_item(pick_reading(CURVE_PM25, 10000, 16383), pv,
               pick_reading(CURVE_PM10, 10000, 16383), mv,
               pick_reading(CURVE_CO2, 40000, 65535), cv,
               pick_reading(CURVE_VOC, 500, 511), vv,
               pick_reading(CURVE_VOC, 500, 511), nv,
               (n % 300) == 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out && !(accepted_items == total_items && expected_q.size() == 0)) begin
      @(negedge clk);
      timed_out = (idle_cycles >= IDLE_LIMIT);
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_q.size() != 0)
      report_mismatch("results never delivered", 32'(expected_q.size()), 32'd0);

    if (timed_out || error_count != 0) begin
      $display("Testbench completed WITH ERRORS");
    end else begin
      $display("Testbench completed without errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ air_quality_index_scorer_core.f @@
sv/aqi_pkg.sv
sv/air_quality_index_scorer_core.sv
bench/tb.sv
